// ----- rtl/iawc_pkg.sv -----
// ----------------------------------------------------------------------------
// iawc_pkg
// Shared types and codes for the insertable array with capacity tracking.
// ----------------------------------------------------------------------------
package iawc_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;
    localparam logic [1:0] OP_SET    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [10:0]        position;
        logic [10:0]        count;
        logic signed [31:0] data_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [10:0]        element_count;
        logic [11:0]        capacity_value;
    } result_t;

endpackage

// ----- rtl/insertable_array_with_capacity.sv -----
// ----------------------------------------------------------------------------
// insertable_array_with_capacity
// Ordered array of signed 32-bit values with size and doubling capacity.
// ----------------------------------------------------------------------------
// A command transaction is taken at a rising edge where start is high and
// busy is low. Each command produces exactly one result transaction: the
// result port holds it for one cycle while done is high, and the receiver
// must take it then.
// Set, rejected commands, inserts at the end and erases that leave no
// entries to move finish in one cycle, and the next command may be taken
// in the cycle that follows. Get goes through the S_GET state because the
// memory read is registered. Insert and erase move entries through the
// single-port-read, single-port-write element memory at one entry per
// cycle: an insert at position p with size n moves n - p entries up, and
// an erase of c entries at position p moves n - p - c entries down.
// Reset clears the size to zero and the capacity to one; memory contents
// are not cleared, since every entry below the size has been written.
// ----------------------------------------------------------------------------
module insertable_array_with_capacity
    import iawc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    command,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = CNT_W + 1;
    localparam int CMP_W  = ((CNT_W > 11) ? CNT_W : 11) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_SHIFT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    size_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic                done_reg;
    result_t             result_reg;

    logic [1:0]          item_op_reg;
    logic [ADDR_W-1:0]   item_pos_reg;
    logic [CNT_W-1:0]    item_cnt_reg;
    logic signed [31:0]  item_val_reg;

    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [ADDR_W-1:0]   wr_addr_reg;
    logic [ADDR_W-1:0]   rd_left_reg;
    logic                wr_pend_reg;
    logic                down_reg;

    logic signed [31:0]  store_mem [DEPTH];
    logic signed [31:0]  mem_rdata_reg;

    logic                accept;
    logic [CMP_W-1:0]    pos_x;
    logic [CMP_W-1:0]    cnt_x;
    logic [CMP_W-1:0]    size_x;
    logic [CMP_W-1:0]    end_x;
    logic [ADDR_W-1:0]   cmd_pos;
    logic                idx_bad;
    logic                ins_bad;
    logic                ins_full;
    logic                ers_bad;
    logic [CNT_W-1:0]    ins_size;
    logic [CAP_W-1:0]    ins_cap;
    logic                shift_done;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic signed [31:0]  mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    always_comb
    begin
        pos_x    = CMP_W'(command.position);
        cnt_x    = CMP_W'(command.count);
        size_x   = CMP_W'(size_reg);
        end_x    = pos_x + cnt_x;
        cmd_pos  = ADDR_W'(command.position);
        idx_bad  = (pos_x >= size_x);
        ins_bad  = (pos_x > size_x);
        ins_full = (size_reg >= CNT_W'(DEPTH));
        ers_bad  = (end_x > size_x);
        ins_size = size_reg + CNT_W'(1);
        ins_cap  = (CAP_W'(ins_size) == cap_reg) ? (cap_reg << 1) : cap_reg;
        shift_done = (rd_left_reg == '0) && !wr_pend_reg;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cmd_pos;
        mem_wdata = command.data_value;
        mem_re    = 1'b0;
        mem_raddr = cmd_pos;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command.operation)
                        OP_INSERT:
                        begin
                            mem_we = !ins_bad && !ins_full && (pos_x == size_x);
                        end
                        OP_SET:
                        begin
                            mem_we = !idx_bad;
                        end
                        OP_GET:
                        begin
                            mem_re = !idx_bad;
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                mem_re    = (rd_left_reg != '0);
                mem_raddr = rd_addr_reg;
                if (wr_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = mem_rdata_reg;
                end
                else if (shift_done && (item_op_reg == OP_INSERT))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = item_pos_reg;
                    mem_wdata = item_val_reg;
                end
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= store_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            size_reg     <= '0;
            cap_reg      <= CAP_W'(1);
            done_reg     <= 1'b0;
            result_reg   <= '0;
            item_op_reg  <= OP_INSERT;
            item_pos_reg <= '0;
            item_cnt_reg <= '0;
            item_val_reg <= '0;
            rd_addr_reg  <= '0;
            wr_addr_reg  <= '0;
            rd_left_reg  <= '0;
            wr_pend_reg  <= 1'b0;
            down_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_op_reg  <= command.operation;
                        item_pos_reg <= cmd_pos;
                        item_cnt_reg <= CNT_W'(command.count);
                        item_val_reg <= command.data_value;
                        wr_pend_reg  <= 1'b0;
                        result_reg.status         <= ST_OK;
                        result_reg.read_value     <= '0;
                        result_reg.element_count  <= 11'(size_reg);
                        result_reg.capacity_value <= 12'(cap_reg);
                        unique case (command.operation)
                            OP_INSERT:
                            begin
                                if (ins_bad)
                                begin
                                    result_reg.status <= ST_RANGE;
                                    done_reg          <= 1'b1;
                                end
                                else if (ins_full)
                                begin
                                    result_reg.status <= ST_FULL;
                                    done_reg          <= 1'b1;
                                end
                                else if (pos_x == size_x)
                                begin
                                    size_reg <= ins_size;
                                    cap_reg  <= ins_cap;
                                    result_reg.element_count  <= 11'(ins_size);
                                    result_reg.capacity_value <= 12'(ins_cap);
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    rd_addr_reg <= ADDR_W'(size_x - CMP_W'(1));
                                    wr_addr_reg <= ADDR_W'(size_reg);
                                    rd_left_reg <= ADDR_W'(size_x - pos_x);
                                    down_reg    <= 1'b1;
                                    state_reg   <= S_SHIFT;
                                end
                            end
                            OP_ERASE:
                            begin
                                if (ers_bad)
                                begin
                                    result_reg.status <= ST_RANGE;
                                    done_reg          <= 1'b1;
                                end
                                else if (end_x == size_x)
                                begin
                                    size_reg <= size_reg - CNT_W'(command.count);
                                    result_reg.element_count <=
                                        11'(size_reg - CNT_W'(command.count));
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    rd_addr_reg <= ADDR_W'(end_x);
                                    wr_addr_reg <= cmd_pos;
                                    rd_left_reg <= ADDR_W'(size_x - end_x);
                                    down_reg    <= 1'b0;
                                    state_reg   <= S_SHIFT;
                                end
                            end
                            OP_GET:
                            begin
                                if (idx_bad)
                                begin
                                    result_reg.status <= ST_RANGE;
                                    done_reg          <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_GET;
                                end
                            end
                            default:
                            begin
                                if (idx_bad)
                                begin
                                    result_reg.status <= ST_RANGE;
                                end
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_GET:
                begin
                    result_reg.read_value <= mem_rdata_reg;
                    done_reg              <= 1'b1;
                    state_reg             <= S_IDLE;
                end
                S_SHIFT:
                begin
                    if (rd_left_reg != '0)
                    begin
                        rd_left_reg <= rd_left_reg - ADDR_W'(1);
                        rd_addr_reg <= down_reg ? (rd_addr_reg - ADDR_W'(1))
                                                : (rd_addr_reg + ADDR_W'(1));
                    end
                    wr_pend_reg <= (rd_left_reg != '0);
                    if (wr_pend_reg)
                    begin
                        wr_addr_reg <= down_reg ? (wr_addr_reg - ADDR_W'(1))
                                                : (wr_addr_reg + ADDR_W'(1));
                    end
                    if (shift_done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                        if (item_op_reg == OP_INSERT)
                        begin
                            size_reg <= ins_size;
                            cap_reg  <= ins_cap;
                            result_reg.element_count  <= 11'(ins_size);
                            result_reg.capacity_value <= 12'(ins_cap);
                        end
                        else
                        begin
                            size_reg <= size_reg - item_cnt_reg;
                            result_reg.element_count <= 11'(size_reg - item_cnt_reg);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
